// ----- hw/rtl/itch_pkg.sv -----
// Shared constants, types and the message type table of the ITCH order message parser.
`default_nettype none

package itch_pkg;

    localparam int MAX_BODY_BYTES = 64;
    localparam int BODY_W         = $clog2(MAX_BODY_BYTES);
    localparam int BYTE_W         = 8;
    localparam int KIND_W         = 3;
    localparam int LOCATE_W       = 16;
    localparam int TIME_W         = 48;
    localparam int REF_W          = 32;
    localparam int QTY_W          = 32;
    localparam int PRICE_W        = 32;

    localparam int REC_W   = LOCATE_W + TIME_W + REF_W + REF_W + 1 + QTY_W + PRICE_W;
    localparam int TDATA_W = ((REC_W + 7) / 8) * 8;
    localparam int PAD_W   = TDATA_W - REC_W;

    localparam logic [KIND_W-1:0] KIND_A    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_F    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_E    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_C    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_X    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_D    = 3'd5;
    localparam logic [KIND_W-1:0] KIND_U    = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SKIP = 3'd7;

    localparam logic [BYTE_W-1:0] SIDE_BUY = "B";

    typedef struct packed {
        logic              known;
        logic [KIND_W-1:0] kind;
        logic [BODY_W-1:0] len;
    } msg_class_t;

    typedef struct packed {
        logic [PRICE_W-1:0]  price;
        logic [QTY_W-1:0]    quantity;
        logic                buy_side;
        logic [REF_W-1:0]    new_order_ref;
        logic [REF_W-1:0]    order_ref;
        logic [TIME_W-1:0]   timestamp_ns;
        logic [LOCATE_W-1:0] stock_locate;
    } record_t;

    function automatic msg_class_t itch_classify(input logic [BYTE_W-1:0] t);
        msg_class_t c;
        c.known = 1'b1;
        c.kind  = KIND_SKIP;
        c.len   = '0;
        case (t)
            "S": c.len = BODY_W'(11);
            "R": c.len = BODY_W'(38);
            "H": c.len = BODY_W'(24);
            "Y": c.len = BODY_W'(19);
            "L": c.len = BODY_W'(25);
            "V": c.len = BODY_W'(34);
            "W": c.len = BODY_W'(11);
            "K": c.len = BODY_W'(27);
            "J": c.len = BODY_W'(34);
            "h": c.len = BODY_W'(20);
            "P": c.len = BODY_W'(43);
            "Q": c.len = BODY_W'(39);
            "B": c.len = BODY_W'(18);
            "I": c.len = BODY_W'(49);
            "N": c.len = BODY_W'(19);
            "O": c.len = BODY_W'(47);
            "A":
            begin
                c.kind = KIND_A;
                c.len  = BODY_W'(35);
            end
            "F":
            begin
                c.kind = KIND_F;
                c.len  = BODY_W'(39);
            end
            "E":
            begin
                c.kind = KIND_E;
                c.len  = BODY_W'(30);
            end
            "C":
            begin
                c.kind = KIND_C;
                c.len  = BODY_W'(35);
            end
            "X":
            begin
                c.kind = KIND_X;
                c.len  = BODY_W'(22);
            end
            "D":
            begin
                c.kind = KIND_D;
                c.len  = BODY_W'(18);
            end
            "U":
            begin
                c.kind = KIND_U;
                c.len  = BODY_W'(34);
            end
            default: c.known = 1'b0;
        endcase
        return c;
    endfunction

    function automatic logic in_range(input logic [BODY_W-1:0] v, input int lo, input int hi);
        return (v >= BODY_W'(lo)) && (v <= BODY_W'(hi));
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/itch_order_message_parser.sv -----
// Top level of the ITCH order message parser: byte framer, field gather and record register.
//
//  channel | dir | request                | payload
//  --------+-----+------------------------+------------------------------------------
//  s_*     | in  | one stream byte        | tdata: byte_value
//  m_*     | out | one order record       | tdata: record fields, tuser: record_kind
//
// One byte is taken per cycle while s_tready is high; a record appears in the cycle after the last body byte.
// The record register frees the input while it is empty or being taken (s_tready).
// Reset clears the framer and drops any record held in the output register.
// A stalled output holds its record and stalls the input only while full.
`default_nettype none

module itch_order_message_parser
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        s_tvalid,
    output logic                       s_tready,
    input  wire  [7:0]                 s_tdata,  // [7:0] byte_value
    output logic                       m_tvalid,
    input  wire                        m_tready,
    output logic [itch_pkg::TDATA_W-1:0] m_tdata, // stock_locate, timestamp_ns, order_ref,
                                                  // new_order_ref, buy_side, quantity,
                                                  // price, zero pad
    output logic [itch_pkg::KIND_W-1:0]  m_tuser  // [2:0] record_kind
);
    import itch_pkg::*;

    logic                in_msg_reg,  in_msg_next;
    logic [KIND_W-1:0]   kind_reg,    kind_next;
    logic [BODY_W-1:0]   off_reg,     off_next;
    logic [BODY_W-1:0]   len_reg,     len_next;
    record_t             acc_reg,     acc_next;
    logic                out_vld_reg, out_vld_next;
    record_t             rec_reg,     rec_next;
    logic [KIND_W-1:0]   rkind_reg,   rkind_next;

    msg_class_t          cls;
    logic                accept;
    logic                emit;
    logic                is_add;
    logic                is_exe;
    logic                is_upd;
    logic [BODY_W-1:0]   off_inc;

    assign s_tready = !out_vld_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign cls      = itch_classify(s_tdata);
    assign is_add   = (kind_reg == KIND_A) || (kind_reg == KIND_F);
    assign is_exe   = (kind_reg == KIND_E) || (kind_reg == KIND_C) || (kind_reg == KIND_X);
    assign is_upd   = (kind_reg == KIND_U);
    assign off_inc  = off_reg + BODY_W'(1);

    always_comb
    begin
        in_msg_next = in_msg_reg;
        kind_next   = kind_reg;
        off_next    = off_reg;
        len_next    = len_reg;
        acc_next    = acc_reg;
        emit        = 1'b0;
        if (accept)
        begin
            if (!in_msg_reg)
            begin
                if (cls.known)
                begin
                    in_msg_next = 1'b1;
                    kind_next   = cls.kind;
                    len_next    = cls.len;
                    off_next    = '0;
                    acc_next    = '0;
                end
            end
            else
            begin
                if (kind_reg != KIND_SKIP)
                begin
                    if (in_range(off_reg, 0, 1))
                        acc_next.stock_locate = {acc_reg.stock_locate[LOCATE_W-9:0], s_tdata};
                    if (in_range(off_reg, 4, 9))
                        acc_next.timestamp_ns = {acc_reg.timestamp_ns[TIME_W-9:0], s_tdata};
                    if (in_range(off_reg, 14, 17))
                        acc_next.order_ref = {acc_reg.order_ref[REF_W-9:0], s_tdata};
                    if (is_add && off_reg == BODY_W'(18))
                        acc_next.buy_side = (s_tdata == SIDE_BUY);
                    if ((is_add && in_range(off_reg, 19, 22))
                        || (is_exe && in_range(off_reg, 18, 21))
                        || (is_upd && in_range(off_reg, 26, 29)))
                        acc_next.quantity = {acc_reg.quantity[QTY_W-9:0], s_tdata};
                    if ((is_add && in_range(off_reg, 31, 34))
                        || (is_upd && in_range(off_reg, 30, 33)))
                        acc_next.price = {acc_reg.price[PRICE_W-9:0], s_tdata};
                    if (is_upd && in_range(off_reg, 22, 25))
                        acc_next.new_order_ref = {acc_reg.new_order_ref[REF_W-9:0], s_tdata};
                end
                if (off_inc == len_reg)
                begin
                    in_msg_next = 1'b0;
                    off_next    = '0;
                    emit        = (kind_reg != KIND_SKIP);
                end
                else
                begin
                    off_next = off_inc;
                end
            end
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        rec_next     = rec_reg;
        rkind_next   = rkind_reg;
        if (emit)
        begin
            out_vld_next = 1'b1;
            rec_next     = acc_next;
            rkind_next   = kind_reg;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_msg_reg  <= 1'b0;
            kind_reg    <= KIND_A;
            off_reg     <= '0;
            len_reg     <= '0;
            acc_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_msg_reg  <= in_msg_next;
            kind_reg    <= kind_next;
            off_reg     <= off_next;
            len_reg     <= len_next;
            acc_reg     <= acc_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg   <= rec_next;
        rkind_reg <= rkind_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = rkind_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, rec_reg};

endmodule

`default_nettype wire

// ----- hw/rtl/itch_checker.sv -----
// Port checker for the ITCH order message parser and its bind.
`default_nettype none

module itch_checker
(
    input wire                         clk,
    input wire                         rst_n,
    input wire                         s_tvalid,
    input wire                         s_tready,
    input wire [7:0]                   s_tdata,
    input wire                         m_tvalid,
    input wire                         m_tready,
    input wire [itch_pkg::TDATA_W-1:0] m_tdata,
    input wire [itch_pkg::KIND_W-1:0]  m_tuser
);
    import itch_pkg::*;

    record_t rec;
    assign rec = record_t'(m_tdata[REC_W-1:0]);

    // hold a stalled record
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("record changed while stalled");

    a_rdy_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty record register");

    a_rose_req: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("record appeared without a byte request");

    a_delete_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_D |->
            rec.quantity == '0 && rec.price == '0 && rec.buy_side == 1'b0)
        else $error("delete record carries shares, price or side");

    a_newref_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_U |-> rec.new_order_ref == '0)
        else $error("new reference set outside replace");

endmodule

bind itch_order_message_parser itch_checker u_itch_checker (.*);

`default_nettype wire
